### sv/mau_pkg.sv
// mau_pkg: shared types, constants and command structs for the modular arithmetic unit
// no dependencies; imported by the controller, datapath and top level
`default_nettype none
package mau_pkg;
	localparam int WORD_COUNT = 4;
	localparam int WORD_BITS = 16;
	localparam int NBITS = WORD_COUNT * WORD_BITS;
	localparam int CNT_W = $clog2(NBITS);
	localparam int PRIME_W = 63;
	localparam logic [PRIME_W-1:0] PRIME_RESET = 63'd4179340454199820289;

	typedef logic [NBITS-1:0] word_t;
	typedef logic [63:0] port_word_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_POW = 3'd3,
		OP_BFLY = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POW_CHECK,
		ST_POW_SQ_LOW,
		ST_POW_SQ,
		ST_POW_ACC,
		ST_MUL_RUN,
		ST_DONE
	} state_t;

	// which operands the shared multiplier takes
	typedef enum logic [1:0] {
		MSEL_AB,
		MSEL_SQSQ,
		MSEL_ACCSQ
	} msel_t;

	// where the multiplier product goes
	typedef enum logic [1:0] {
		MDST_RES,
		MDST_SQ,
		MDST_ACC
	} mdst_t;

	typedef struct packed {
		logic load;      // capture operands and opcode
		logic simple;    // compute add/sub/butterfly/unknown into result
		logic mul_start; // load multiplier with selected operands
		msel_t mul_sel;
		logic mul_step;  // one interleaved step
		logic mul_wb;    // write product to destination
		mdst_t mul_dst;
		logic exp_shift; // shift exponent right
		logic acc_from_sq;
		logic res_one;   // result is 1 (zero exponent)
		logic res_from_acc;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic exp_zero;
		logic exp_lsb;
		logic mul_last;
	} dp_stat_t;
endpackage
`default_nettype wire

### sv/mau_datapath.sv
// mau_datapath: operand registers, add/sub unit and bit-serial interleaved multiplier
// depends on mau_pkg
`default_nettype none
module mau_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire mau_pkg::dp_cmd_t cmd,
	output mau_pkg::dp_stat_t stat,
	input wire logic [2:0] opcode,
	input wire logic [63:0] operand_a,
	input wire logic [63:0] operand_b,
	input wire logic [mau_pkg::PRIME_W-1:0] prime,
	output logic [63:0] result,
	output logic [63:0] second_result
);
	import mau_pkg::*;

	logic [2:0] op_q;
	word_t a_q, b_q, sq_q, acc_q, e_q;
	word_t mc_q, ma_q, mb_q;
	logic [CNT_W-1:0] cnt_q;
	word_t res_q, res2_q;
	word_t p;
	word_t add_s, sub_d, add_r, sub_r;
	logic add_c;
	word_t dbl, dbl_r, plus, nxt;

	assign p = word_t'({1'b0, prime});

	// add with carry, then one conditional subtract
	always_comb begin
		{add_c, add_s} = {1'b0, a_q} + {1'b0, b_q};
		if (add_c) add_r = add_s - p;
		else add_r = (add_s < p) ? add_s : add_s - p;
		sub_d = a_q - b_q;
		sub_r = (a_q < b_q) ? sub_d + p : sub_d;
	end

	// one multiplier step: double, reduce, add b, reduce
	always_comb begin
		dbl = {mc_q[NBITS-2:0], 1'b0};
		dbl_r = (dbl < p) ? dbl : dbl - p;
		plus = ma_q[NBITS-1] ? dbl_r + mb_q : dbl_r;
		nxt = (plus < p) ? plus : plus - p;
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				op_q <= opcode;
				a_q <= word_t'(operand_a);
				b_q <= word_t'(operand_b);
				sq_q <= word_t'(operand_a);
				e_q <= word_t'(operand_b);
			end
			if (cmd.simple) begin
				unique case (op_q)
					OP_ADD: begin res_q <= add_r; res2_q <= '0; end
					OP_SUB: begin res_q <= sub_r; res2_q <= '0; end
					OP_BFLY: begin res_q <= add_r; res2_q <= sub_r; end
					default: begin res_q <= '0; res2_q <= '0; end
				endcase
			end
			if (cmd.mul_start) begin
				mc_q <= '0;
				cnt_q <= '0;
				case (cmd.mul_sel)
					MSEL_AB: begin ma_q <= a_q; mb_q <= b_q; end
					MSEL_SQSQ: begin ma_q <= sq_q; mb_q <= sq_q; end
					default: begin ma_q <= acc_q; mb_q <= sq_q; end
				endcase
			end
			if (cmd.mul_step) begin
				mc_q <= nxt;
				ma_q <= {ma_q[NBITS-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.mul_wb) begin
				case (cmd.mul_dst)
					MDST_RES: begin res_q <= mc_q; res2_q <= '0; end
					MDST_SQ: sq_q <= mc_q;
					default: acc_q <= mc_q;
				endcase
			end
			if (cmd.exp_shift) e_q <= e_q >> 1;
			if (cmd.acc_from_sq) acc_q <= sq_q;
			if (cmd.res_one) begin res_q <= word_t'(1); res2_q <= '0; end
			if (cmd.res_from_acc) begin res_q <= acc_q; res2_q <= '0; end
		end
	end

	assign stat.op = opcode_t'(op_q);
	assign stat.exp_zero = (e_q == '0);
	assign stat.exp_lsb = e_q[0];
	assign stat.mul_last = (cnt_q == CNT_W'(NBITS - 1));
	assign result = 64'(res_q);
	assign second_result = 64'(res2_q);
endmodule
`default_nettype wire

### sv/mau_ctrl.sv
// mau_ctrl: sequencer for operations, multiply steps and square-and-multiply
// depends on mau_pkg
`default_nettype none
module mau_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output mau_pkg::dp_cmd_t cmd,
	input wire mau_pkg::dp_stat_t stat
);
	import mau_pkg::*;

	state_t state_q, state_d;
	logic start_q, start_d; // set on the last multiply step; ST_DONE then writes the product back
	mdst_t dst_q, dst_d;
	state_t ret_q, ret_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			dst_q <= MDST_RES;
			ret_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
			dst_q <= dst_d;
			ret_q <= ret_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		start_d = 1'b0;
		dst_d = dst_q;
		ret_d = ret_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_POW_CHECK;
				end
			end
			ST_POW_CHECK: begin
				// dispatch on opcode
				case (stat.op)
					OP_MUL: begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel = MSEL_AB;
						dst_d = MDST_RES;
						ret_d = ST_DONE;
						state_d = ST_MUL_RUN;
					end
					OP_POW: begin
						if (stat.exp_zero) begin
							cmd.res_one = 1'b1;
							state_d = ST_DONE;
						end else state_d = ST_POW_SQ_LOW;
					end
					default: begin
						cmd.simple = 1'b1;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_POW_SQ_LOW: begin
				// square until the lowest set exponent bit
				if (!stat.exp_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MSEL_SQSQ;
					cmd.exp_shift = 1'b1;
					dst_d = MDST_SQ;
					ret_d = ST_POW_SQ_LOW;
					state_d = ST_MUL_RUN;
				end else begin
					cmd.acc_from_sq = 1'b1;
					cmd.exp_shift = 1'b1;
					state_d = ST_POW_SQ;
				end
			end
			ST_POW_SQ: begin
				if (stat.exp_zero) begin
					cmd.res_from_acc = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MSEL_SQSQ;
					dst_d = MDST_SQ;
					ret_d = ST_POW_ACC;
					state_d = ST_MUL_RUN;
				end
			end
			ST_POW_ACC: begin
				cmd.exp_shift = 1'b1;
				if (stat.exp_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MSEL_ACCSQ;
					dst_d = MDST_ACC;
					ret_d = ST_POW_SQ;
					state_d = ST_MUL_RUN;
				end else state_d = ST_POW_SQ;
			end
			ST_MUL_RUN: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last) begin
					start_d = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// write back a finished product before leaving
				if (start_q) begin
					cmd.mul_wb = 1'b1;
					cmd.mul_dst = dst_q;
					state_d = ret_q;
				end else begin
					out_valid = 1'b1;
					if (out_ready) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### sv/modular_arith_unit.sv
// Modular arithmetic unit over a configured odd prime below 2^63. One item at a time:
// add, subtract and butterfly are computed combinationally and registered as the result;
// multiply uses the bit-serial interleaved multiplier, which handles one bit of operand_a
// per cycle over 64 steps between a launch and a write-back; power does up to two
// squarings or multiplies per exponent bit on it. Input is ready again in the cycle after
// the result is taken. The user must write the prime through the cfg port only while idle;
// the block does not enforce it. Depends on mau_pkg, mau_ctrl and mau_datapath.
`default_nettype none
module modular_arith_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] opcode,
	input wire logic [63:0] operand_a,
	input wire logic [63:0] operand_b,
	output logic out_valid,
	input wire logic out_ready,
	output logic [63:0] result,
	output logic [63:0] second_result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [62:0] prime
);
	import mau_pkg::*;

	logic [PRIME_W-1:0] prime_q;
	dp_cmd_t cmd;
	dp_stat_t stat;

	// prime register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prime_q <= PRIME_RESET;
		else if (cfg_valid) prime_q <= prime;
	end

	mau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .stat(stat)
	);

	mau_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
		.prime(prime_q), .result(result), .second_result(second_result)
	);
endmodule
`default_nettype wire

### bench/modular_arith_unit_tb.sv
// modular_arith_unit_tb: self-checking bench for the modular arithmetic unit
// directed table, then random phases under several primes and idle patterns
// depends on mau_pkg and modular_arith_unit
`timescale 1ns / 1ps
module modular_arith_unit_tb;
	import mau_pkg::*;

	localparam int WATCHDOG_LIMIT = 60000;
	localparam int PHASE_ITEMS = 150;
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam logic [63:0] ALL_ONES = '1;
	localparam logic [63:0] RP = 64'd4179340454199820289;

	typedef struct {
		logic [63:0] sum;
		logic [63:0] diff;
	} outcome_t;

	typedef struct {
		logic [2:0] op;
		logic [63:0] a;
		logic [63:0] b;
		bit fixed;
		logic [63:0] want_r;
		logic [63:0] want_r2;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] opcode = '0;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] result;
	logic [63:0] second_result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [62:0] prime = '0;

	logic [62:0] modulus = PRIME_RESET;
	outcome_t pending_q[$];
	int error_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int op_count[8];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	modular_arith_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result(result), .second_result(second_result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .prime(prime)
	);

	// ---------------- arithmetic predictor ----------------
	function automatic word_t cur_p();
		return word_t'(modulus);
	endfunction

	function automatic word_t cond_sub(word_t x);
		return (x < cur_p()) ? x : word_t'(x - cur_p());
	endfunction

	function automatic word_t fold_sum(word_t a, word_t b);
		logic [NBITS:0] full;
		begin
			full = {1'b0, a} + {1'b0, b};
			if (full[NBITS])
				return word_t'(full[NBITS-1:0] - cur_p());
			return cond_sub(full[NBITS-1:0]);
		end
	endfunction

	function automatic word_t fold_diff(word_t a, word_t b);
		word_t d;
		begin
			d = a - b;
			if (a < b)
				d = d + cur_p();
			return d;
		end
	endfunction

	function automatic word_t interleaved_product(word_t a, word_t b);
		word_t c;
		begin
			c = '0;
			for (int i = 0; i < NBITS; i++) begin
				c = cond_sub(c << 1);
				if (a[NBITS-1])
					c = c + b;
				a = a << 1;
				c = cond_sub(c);
			end
			return c;
		end
	endfunction

	function automatic word_t power_mod(word_t base, word_t e);
		word_t sq;
		word_t acc;
		begin
			if (e == '0)
				return word_t'(1);
			sq = base;
			while (!e[0]) begin
				sq = interleaved_product(sq, sq);
				e = e >> 1;
			end
			acc = sq;
			e = e >> 1;
			while (e != '0) begin
				sq = interleaved_product(sq, sq);
				if (e[0])
					acc = interleaved_product(acc, sq);
				e = e >> 1;
			end
			return acc;
		end
	endfunction

	function automatic outcome_t predict_item(logic [2:0] op, logic [63:0] a, logic [63:0] b);
		outcome_t o;
		word_t wa;
		word_t wb;
		begin
			wa = word_t'(a);
			wb = word_t'(b);
			o.sum = '0;
			o.diff = '0;
			case (op)
				OP_ADD: o.sum = fold_sum(wa, wb);
				OP_SUB: o.sum = fold_diff(wa, wb);
				OP_MUL: o.sum = interleaved_product(wa, wb);
				OP_POW: o.sum = power_mod(wa, wb);
				OP_BFLY: begin
					o.sum = fold_sum(wa, wb);
					o.diff = fold_diff(wa, wb);
				end
				default: ;
			endcase
			return o;
		end
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// receiver with random stalls, compares against oldest pending item
	always @(posedge clk) begin
		outcome_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_q.size() == 0) begin
					report_mismatch("unexpected result", result, '0);
				end else begin
					w = pending_q.pop_front();
					if (result !== w.sum)
						report_mismatch("result", result, w.sum);
					if (second_result !== w.diff)
						report_mismatch("second_result", second_result, w.diff);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d quiet cycles", quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic send_item(vector_t v);
		outcome_t o;
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			opcode <= v.op;
			operand_a <= v.a;
			operand_b <= v.b;
			do @(posedge clk); while (!in_ready);
			if (v.fixed) begin
				o.sum = v.want_r;
				o.diff = v.want_r2;
			end else begin
				o = predict_item(v.op, v.a, v.b);
			end
			pending_q.push_back(o);
			items_sent++;
			op_count[v.op]++;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// prime is only written with nothing in flight
	task automatic write_prime(logic [62:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		prime <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		modulus = v;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_operand();
		int r;
		begin
			r = $urandom_range(99);
			if (r < 8) return '0;
			if (r < 16) return cur_p() - 1;
			if (r < 20) return ALL_ONES;
			if (r < 30) return rand64();
			return rand64() % cur_p();
		end
	endfunction

	function automatic vector_t random_vector();
		vector_t v;
		int r;
		begin
			r = $urandom_range(99);
			v.fixed = 0;
			v.want_r = '0;
			v.want_r2 = '0;
			if (r < 18) v.op = OP_ADD;
			else if (r < 36) v.op = OP_SUB;
			else if (r < 62) v.op = OP_MUL;
			else if (r < 74) v.op = OP_POW;
			else if (r < 95) v.op = OP_BFLY;
			else v.op = 3'($urandom_range(5, 7));
			v.a = pick_operand();
			v.b = pick_operand();
			// keep most exponents short, power cost grows with exponent width
			if (v.op == OP_POW && $urandom_range(99) < 85)
				v.b = rand64() & ((64'd1 << $urandom_range(1, 10)) - 1);
			return v;
		end
	endfunction

	vector_t directed[] = '{
		'{OP_ADD,  64'd0,    64'd0,    1, 64'd0, 64'd0},
		'{OP_ADD,  RP - 1,   64'd1,    1, 64'd0, 64'd0},
		'{OP_ADD,  ALL_ONES, ALL_ONES, 0, 64'd0, 64'd0},
		'{OP_SUB,  64'd0,    64'd1,    1, RP - 1, 64'd0},
		'{OP_SUB,  64'd5,    64'd5,    1, 64'd0, 64'd0},
		'{OP_SUB,  ALL_ONES, 64'd0,    0, 64'd0, 64'd0},
		'{OP_MUL,  64'd0,    RP - 1,   1, 64'd0, 64'd0},
		'{OP_MUL,  64'd1,    RP - 1,   1, RP - 1, 64'd0},
		'{OP_MUL,  RP - 1,   RP - 1,   1, 64'd1, 64'd0},
		'{OP_MUL,  ALL_ONES, ALL_ONES, 0, 64'd0, 64'd0},
		'{OP_MUL,  ALL_ONES, RP - 1,   0, 64'd0, 64'd0},
		'{OP_POW,  64'd7,    64'd0,    1, 64'd1, 64'd0},
		'{OP_POW,  64'd0,    64'd5,    1, 64'd0, 64'd0},
		'{OP_POW,  64'd2,    64'd1,    1, 64'd2, 64'd0},
		'{OP_POW,  RP - 1,   64'd2,    1, 64'd1, 64'd0},
		'{OP_POW,  64'd3,    ALL_ONES, 0, 64'd0, 64'd0},
		'{OP_POW,  64'd2,    64'h8000000000000000, 0, 64'd0, 64'd0},
		'{OP_BFLY, 64'd3,    64'd5,    1, 64'd8, RP - 2},
		'{OP_BFLY, RP - 1,   RP - 1,   0, 64'd0, 64'd0},
		'{OP_BFLY, ALL_ONES, 64'd1,    0, 64'd0, 64'd0},
		'{OP_RSVD5, ALL_ONES, ALL_ONES, 1, 64'd0, 64'd0},
		'{OP_RSVD6, 64'd1,   64'd2,    1, 64'd0, 64'd0},
		'{OP_RSVD7, 64'd9,   64'd3,    1, 64'd0, 64'd0}
	};

	// smallest, largest, three mid-size primes, and back to the reset value
	logic [62:0] prime_list[6] = '{
		63'd3, 63'h7FFFFFFFFFFFFFFF, 63'h1FFFFFFFFFFFFFFF,
		63'd65537, 63'd1000000007, PRIME_RESET
	};

	initial begin
		foreach (op_count[i]) op_count[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i]);

		for (int ph = 0; ph < 6; ph++) begin
			write_prime(prime_list[ph]);
			// receiver stalls most first, then the sender, then neither
			if (ph < 2) begin
				send_idle_pct = 15;
				recv_idle_pct = 57;
			end else if (ph < 4) begin
				send_idle_pct = 57;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(random_vector());
		end

		wait_drained();
		repeat (100) @(posedge clk);
		$display("covered %0d items (add %0d sub %0d mul %0d pow %0d bfly %0d other %0d)",
			items_sent, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
			op_count[OP_POW], op_count[OP_BFLY],
			op_count[OP_RSVD5] + op_count[OP_RSVD6] + op_count[OP_RSVD7]);
		$display("%0d results checked across 7 prime settings, %0d mismatches",
			results_seen, error_count);
		if (error_count == 0 && pending_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### files.f
sv/mau_pkg.sv
sv/mau_datapath.sv
sv/mau_ctrl.sv
sv/modular_arith_unit.sv
bench/modular_arith_unit_tb.sv
